>>> rtl/tvg_pkg.sv
// Package for the torus vertex generator: widths, codes, item structs,
// the quarter-wave sine table and small helper functions.
// Depends on nothing.
package tvg_pkg;

    localparam int MAX_STEPS        = 256;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
    localparam int TBL_W            = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_W            = $clog2(QUARTER);

    localparam int STEP_W   = 9;
    localparam int GRID_W   = 9;
    localparam int RADIUS_W = 16;
    localparam int SLOT_W   = 19;
    localparam int VIDX_W   = 17;
    localparam int POS_W    = 18;
    localparam int NORM_W   = 16;
    localparam int TEX_W    = 17;
    localparam int FRAC_W   = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 176;
    localparam int CFG_AW   = 4;

    localparam logic [1:0] REG_RING_RADIUS = 2'd0;
    localparam logic [1:0] REG_TUBE_RADIUS = 2'd1;
    localparam logic [1:0] REG_RING_STEPS  = 2'd2;
    localparam logic [1:0] REG_TUBE_STEPS  = 2'd3;

    localparam logic [2:0] LAST_INDEX = 3'd6;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_INDEX  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CALC_IDLE,
        CALC_DIV0,
        CALC_DIV1,
        CALC_LUT,
        CALC_MUL1,
        CALC_SUM,
        CALC_MUL2,
        CALC_DONE
    } calc_state_t;

    // queue entry: one classified grid point
    typedef struct packed {
        logic              reject;
        logic              has_quad;
        logic [GRID_W-1:0] ring_pos;
        logic [GRID_W-1:0] tube_pos;
        logic [VIDX_W-1:0] cur;
        logic [VIDX_W-1:0] nxt;
        logic [SLOT_W-1:0] base;
    } qent_t;

    // finished vertex record handed to the emitter
    typedef struct packed {
        logic              reject;
        logic              has_quad;
        logic [VIDX_W-1:0] cur;
        logic [VIDX_W-1:0] nxt;
        logic [SLOT_W-1:0] base;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [NORM_W-1:0] norm_x;
        logic [NORM_W-1:0] norm_y;
        logic [NORM_W-1:0] norm_z;
        logic [TEX_W-1:0]  tex_u;
        logic [TEX_W-1:0]  tex_v;
    } vrec_t;

    typedef logic [14:0] qtab_t [0:QUARTER];

    localparam longint unsigned HALF_PI_Q28 = 64'd421657428;
    localparam longint unsigned Q28_ONE     = 64'd1 << 28;

    function automatic qtab_t build_qtab();
        qtab_t t;
        longint unsigned x, x2, r, s, e;
        for (int k = 0; k <= QUARTER; k++) begin
            x  = (longint'(k) * HALF_PI_Q28) / QUARTER;
            x2 = (x * x) >> 28;
            r  = Q28_ONE;
            r  = Q28_ONE - ((x2 * r) >> 28) / 64'd156;
            r  = Q28_ONE - ((x2 * r) >> 28) / 64'd110;
            r  = Q28_ONE - ((x2 * r) >> 28) / 64'd72;
            r  = Q28_ONE - ((x2 * r) >> 28) / 64'd42;
            r  = Q28_ONE - ((x2 * r) >> 28) / 64'd20;
            r  = Q28_ONE - ((x2 * r) >> 28) / 64'd6;
            s  = (x * r) >> 28;
            e  = (s + 64'd8192) >> 14;
            if (e > 64'd16384) begin
                e = 64'd16384;
            end
            t[k] = e[14:0];
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    // full-wave sine from the quarter table, Q1.14
    function automatic logic signed [NORM_W-1:0] sine_at(input logic [TBL_W-1:0] idx);
        logic [QTR_W-1:0] rr;
        logic [QTR_W:0]   addr;
        logic [15:0]      mag;
        rr   = idx[QTR_W-1:0];
        addr = idx[TBL_W-2] ? ((QTR_W+1)'(QUARTER) - {1'b0, rr}) : {1'b0, rr};
        mag  = {1'b0, QTAB[addr]};
        return idx[TBL_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [STEP_W-1:0] clamp_steps(input logic [STEP_W-1:0] s);
        if (s == '0) begin
            return STEP_W'(1);
        end else if (int'(s) > MAX_STEPS) begin
            return STEP_W'(MAX_STEPS);
        end
        return s;
    endfunction

endpackage

>>> rtl/tvg_front.sv
// Front end: accepts grid points, classifies them and works out slot numbers.
// Depends on tvg_pkg.
module tvg_front (
    input  logic [tvg_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [tvg_pkg::STEP_W-1:0]   ring_steps,
    input  logic [tvg_pkg::STEP_W-1:0]   tube_steps,
    output tvg_pkg::qent_t               entry
);

    logic [tvg_pkg::GRID_W-1:0] i_pos, j_pos;
    logic [18:0]                cur_full;
    logic [18:0]                cell_num;

    assign i_pos = s_tdata[8:0];
    assign j_pos = s_tdata[17:9];

    always_comb begin
        cur_full       = 19'(i_pos) * 19'({1'b0, tube_steps} + 10'd1) + 19'(j_pos);
        cell_num       = cur_full - 19'(i_pos);
        entry.ring_pos = i_pos;
        entry.tube_pos = j_pos;
        entry.reject   = (i_pos > ring_steps) || (j_pos > tube_steps);
        entry.has_quad = (i_pos < ring_steps) && (j_pos < tube_steps);
        entry.cur      = cur_full[tvg_pkg::VIDX_W-1:0];
        entry.nxt      = cur_full[tvg_pkg::VIDX_W-1:0] + tvg_pkg::VIDX_W'(tube_steps)
                         + tvg_pkg::VIDX_W'(1);
        // six indices per cell
        entry.base     = (cell_num << 2) + (cell_num << 1);
    end

endmodule

>>> rtl/tvg_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
// Depends on tvg_pkg.
module tvg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_en,
    input  tvg_pkg::qent_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output tvg_pkg::qent_t rd_data
);

    tvg_pkg::qent_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

>>> rtl/tvg_calc.sv
// Back end arithmetic: angle division, sine lookup and the position/normal
// products, one grid point at a time. Depends on tvg_pkg.
module tvg_calc (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  tvg_pkg::qent_t                q_data,
    output logic                          q_pop,
    input  logic [tvg_pkg::RADIUS_W-1:0]  ring_radius,
    input  logic [tvg_pkg::RADIUS_W-1:0]  tube_radius,
    input  logic [tvg_pkg::STEP_W-1:0]    ring_steps,
    input  logic [tvg_pkg::STEP_W-1:0]    tube_steps,
    output logic                          rec_valid,
    input  logic                          rec_ready,
    output tvg_pkg::vrec_t                rec
);

    tvg_pkg::calc_state_t state_reg, state_next;

    logic [tvg_pkg::STEP_W-1:0]   rem_a_reg, rem_b_reg;
    logic [tvg_pkg::FRAC_W-1:0]   frac_a_reg, frac_b_reg;
    logic                         whole_a_reg, whole_b_reg;
    logic signed [15:0]           sa_reg, ca_reg, sb_reg, cb_reg;
    logic signed [17:0]           rcb_reg;
    logic signed [17:0]           w_reg;
    tvg_pkg::vrec_t               rec_reg;

    logic [tvg_pkg::STEP_W+7:0]   div_a, div_b;
    logic [tvg_pkg::TBL_W-1:0]    ia, ib;
    logic signed [32:0]           p_rcb, p_rsb;
    logic signed [31:0]           p_cbca, p_cbsa;
    logic signed [33:0]           p_wca, p_wsa;

    // eight restoring division steps: {remainder, quotient bits}
    function automatic logic [tvg_pkg::STEP_W+7:0] div8(
        input logic [tvg_pkg::STEP_W-1:0] rem_in,
        input logic [tvg_pkg::STEP_W-1:0] d
    );
        logic [tvg_pkg::STEP_W:0]   t;
        logic [tvg_pkg::STEP_W-1:0] rem;
        logic [7:0]                 q;
        rem = rem_in;
        q   = '0;
        for (int k = 7; k >= 0; k--) begin
            t = {rem, 1'b0};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                q[k] = 1'b1;
            end
            rem = t[tvg_pkg::STEP_W-1:0];
        end
        return {rem, q};
    endfunction

    function automatic logic [tvg_pkg::POS_W-1:0] sat18(input logic signed [33:0] p);
        logic signed [19:0] v;
        v = p[33:14];
        if (v > 20'sd131071) begin
            return 18'h1FFFF;
        end else if (v < -20'sd131072) begin
            return 18'h20000;
        end
        return v[17:0];
    endfunction

    assign div_a = div8(rem_a_reg, ring_steps);
    assign div_b = div8(rem_b_reg, tube_steps);
    assign ia    = frac_a_reg[tvg_pkg::FRAC_W-1 -: tvg_pkg::TBL_W];
    assign ib    = frac_b_reg[tvg_pkg::FRAC_W-1 -: tvg_pkg::TBL_W];

    assign p_rcb  = $signed({1'b0, tube_radius}) * cb_reg;
    assign p_rsb  = $signed({1'b0, tube_radius}) * sb_reg;
    assign p_cbca = cb_reg * ca_reg;
    assign p_cbsa = cb_reg * sa_reg;
    assign p_wca  = w_reg * ca_reg;
    assign p_wsa  = w_reg * sa_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tvg_pkg::CALC_IDLE: begin
                if (q_valid) begin
                    state_next = q_data.reject ? tvg_pkg::CALC_DONE : tvg_pkg::CALC_DIV0;
                end
            end
            tvg_pkg::CALC_DIV0: state_next = tvg_pkg::CALC_DIV1;
            tvg_pkg::CALC_DIV1: state_next = tvg_pkg::CALC_LUT;
            tvg_pkg::CALC_LUT:  state_next = tvg_pkg::CALC_MUL1;
            tvg_pkg::CALC_MUL1: state_next = tvg_pkg::CALC_SUM;
            tvg_pkg::CALC_SUM:  state_next = tvg_pkg::CALC_MUL2;
            tvg_pkg::CALC_MUL2: state_next = tvg_pkg::CALC_DONE;
            tvg_pkg::CALC_DONE: begin
                if (rec_ready) begin
                    if (q_valid) begin
                        state_next = q_data.reject ? tvg_pkg::CALC_DONE
                                                   : tvg_pkg::CALC_DIV0;
                    end else begin
                        state_next = tvg_pkg::CALC_IDLE;
                    end
                end
            end
            default: state_next = tvg_pkg::CALC_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        rec_valid = (state_reg == tvg_pkg::CALC_DONE);
        q_pop     = q_valid && ((state_reg == tvg_pkg::CALC_IDLE) ||
                                ((state_reg == tvg_pkg::CALC_DONE) && rec_ready));
    end

    assign rec = rec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tvg_pkg::CALC_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            whole_a_reg      <= (q_data.ring_pos == ring_steps);
            whole_b_reg      <= (q_data.tube_pos == tube_steps);
            rem_a_reg        <= (q_data.ring_pos == ring_steps) ? '0 : q_data.ring_pos;
            rem_b_reg        <= (q_data.tube_pos == tube_steps) ? '0 : q_data.tube_pos;
            rec_reg.reject   <= q_data.reject;
            rec_reg.has_quad <= q_data.has_quad;
            rec_reg.cur      <= q_data.cur;
            rec_reg.nxt      <= q_data.nxt;
            rec_reg.base     <= q_data.base;
        end
        unique case (state_reg)
            tvg_pkg::CALC_DIV0: begin
                rem_a_reg        <= div_a[tvg_pkg::STEP_W+7:8];
                rem_b_reg        <= div_b[tvg_pkg::STEP_W+7:8];
                frac_a_reg[15:8] <= div_a[7:0];
                frac_b_reg[15:8] <= div_b[7:0];
            end
            tvg_pkg::CALC_DIV1: begin
                frac_a_reg[7:0] <= div_a[7:0];
                frac_b_reg[7:0] <= div_b[7:0];
            end
            tvg_pkg::CALC_LUT: begin
                sa_reg        <= tvg_pkg::sine_at(ia);
                ca_reg        <= tvg_pkg::sine_at(ia + tvg_pkg::TBL_W'(tvg_pkg::QUARTER));
                sb_reg        <= tvg_pkg::sine_at(ib);
                cb_reg        <= tvg_pkg::sine_at(ib + tvg_pkg::TBL_W'(tvg_pkg::QUARTER));
                rec_reg.tex_u <= {whole_a_reg, frac_a_reg};
                rec_reg.tex_v <= {whole_b_reg, frac_b_reg};
            end
            tvg_pkg::CALC_MUL1: begin
                rcb_reg        <= p_rcb[31:14];
                rec_reg.pos_y  <= p_rsb[31:14];
                rec_reg.norm_x <= p_cbca[29:14];
                rec_reg.norm_y <= sb_reg;
                rec_reg.norm_z <= p_cbsa[29:14];
            end
            tvg_pkg::CALC_SUM: begin
                w_reg <= $signed({2'b00, ring_radius}) + rcb_reg;
            end
            tvg_pkg::CALC_MUL2: begin
                rec_reg.pos_x <= sat18(p_wca);
                rec_reg.pos_z <= sat18(p_wsa);
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/tvg_emit.sv
// Result sequencer: sends the vertex and then, for a full cell, the six cell
// indices of one record, or one reject item. Depends on tvg_pkg.
module tvg_emit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           rec_valid,
    output logic                           rec_ready,
    input  tvg_pkg::vrec_t                 rec,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tvg_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);

    tvg_pkg::vrec_t rec_reg;
    logic [2:0]     cnt_reg;
    logic           busy_reg;
    logic           fire;
    logic [tvg_pkg::VIDX_W-1:0] idx_val;
    tvg_pkg::kind_t kind;

    assign m_tvalid  = busy_reg;
    assign fire      = busy_reg && m_tready;
    assign rec_ready = !busy_reg || (fire && m_tlast);

    always_comb begin
        m_tlast = rec_reg.reject || ((cnt_reg == 3'd0) && !rec_reg.has_quad) ||
                  (cnt_reg == tvg_pkg::LAST_INDEX);
        unique case (cnt_reg)
            3'd1:    idx_val = rec_reg.cur;
            3'd2:    idx_val = rec_reg.nxt;
            3'd3:    idx_val = rec_reg.cur + tvg_pkg::VIDX_W'(1);
            3'd4:    idx_val = rec_reg.cur + tvg_pkg::VIDX_W'(1);
            3'd5:    idx_val = rec_reg.nxt;
            3'd6:    idx_val = rec_reg.nxt + tvg_pkg::VIDX_W'(1);
            default: idx_val = '0;
        endcase
        m_tdata = '0;
        if (rec_reg.reject) begin
            kind = tvg_pkg::KIND_REJECT;
        end else if (cnt_reg == 3'd0) begin
            kind            = tvg_pkg::KIND_VERTEX;
            m_tdata[18:0]   = tvg_pkg::SLOT_W'(rec_reg.cur);
            m_tdata[36:19]  = rec_reg.pos_x;
            m_tdata[54:37]  = rec_reg.pos_y;
            m_tdata[72:55]  = rec_reg.pos_z;
            m_tdata[88:73]  = rec_reg.norm_x;
            m_tdata[104:89] = rec_reg.norm_y;
            m_tdata[120:105] = rec_reg.norm_z;
            m_tdata[137:121] = rec_reg.tex_u;
            m_tdata[154:138] = rec_reg.tex_v;
        end else begin
            kind             = tvg_pkg::KIND_INDEX;
            m_tdata[18:0]    = rec_reg.base + tvg_pkg::SLOT_W'(cnt_reg - 3'd1);
            m_tdata[171:155] = idx_val;
        end
        m_tuser = kind;
    end

    always_ff @(posedge aclk) begin
        if (rec_valid && rec_ready) begin
            rec_reg <= rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            if (rec_valid && rec_ready) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end else if (fire) begin
                if (m_tlast) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

endmodule

>>> rtl/torus_vertex_generator.sv
// Top level of the torus vertex generator: register file, front end, queue,
// arithmetic back end and result sequencer. Depends on tvg_pkg and all tvg_ modules.
//
//  channel   direction  handshake              payload
//  s_        in         s_tvalid / s_tready    grid point (ring_pos, tube_pos)
//  m_        out        m_tvalid / m_tready    vertex, triangle index or reject
//  apb       in         psel & penable         four configuration registers
//
// In the back end a grid point passes through a load, two division steps
// (8 quotient bits each), sine lookup, two multiply stages and one add;
// the result sequencer sends up to 7 items, overlapped with the next point.
// The back end sequencer works on one point at a time, and every item leaves
// by the single result port. Reset (aresetn low, synchronous) empties the
// queue and pipeline and restores register defaults. A stalled result stream
// backs up into the two-entry queue, then drops s_tready.
module torus_vertex_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: ring_pos [8:0], tube_pos [17:9], zero pad [23:18]
    input  logic [tvg_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: slot, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
    //        index_value, zero pad
    output logic [tvg_pkg::M_DATA_W-1:0]   m_tdata,
    // tuser: kind [1:0]
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tvg_pkg::CFG_AW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [tvg_pkg::RADIUS_W-1:0] ring_radius_reg, tube_radius_reg;
    logic [tvg_pkg::STEP_W-1:0]   ring_steps_reg, tube_steps_reg;
    logic [tvg_pkg::STEP_W-1:0]   m_steps, n_steps;
    logic [1:0]                   reg_sel;

    tvg_pkg::qent_t front_entry, q_head;
    tvg_pkg::vrec_t rec;
    logic           q_full, q_valid, q_pop;
    logic           rec_valid, rec_ready;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];

    // write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_radius_reg <= 16'd256;
            tube_radius_reg <= 16'd64;
            ring_steps_reg  <= 9'd16;
            tube_steps_reg  <= 9'd8;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                tvg_pkg::REG_RING_RADIUS: ring_radius_reg <= pwdata[15:0];
                tvg_pkg::REG_TUBE_RADIUS: tube_radius_reg <= pwdata[15:0];
                tvg_pkg::REG_RING_STEPS:  ring_steps_reg  <= pwdata[8:0];
                tvg_pkg::REG_TUBE_STEPS:  tube_steps_reg  <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            tvg_pkg::REG_RING_RADIUS: prdata = 32'(ring_radius_reg);
            tvg_pkg::REG_TUBE_RADIUS: prdata = 32'(tube_radius_reg);
            tvg_pkg::REG_RING_STEPS:  prdata = 32'(ring_steps_reg);
            tvg_pkg::REG_TUBE_STEPS:  prdata = 32'(tube_steps_reg);
            default:                  prdata = '0;
        endcase
    end

    // hold step counts inside 1..MAX_STEPS
    assign m_steps  = tvg_pkg::clamp_steps(ring_steps_reg);
    assign n_steps  = tvg_pkg::clamp_steps(tube_steps_reg);
    assign s_tready = !q_full;

    tvg_front u_front (
        .s_tdata    (s_tdata),
        .ring_steps (m_steps),
        .tube_steps (n_steps),
        .entry      (front_entry)
    );

    tvg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_tvalid && s_tready),
        .wr_data  (front_entry),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_head)
    );

    tvg_calc u_calc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .ring_radius (ring_radius_reg),
        .tube_radius (tube_radius_reg),
        .ring_steps  (m_steps),
        .tube_steps  (n_steps),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec         (rec)
    );

    tvg_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> tb/torus_vertex_generator_tb.sv
// Self-checking testbench for torus_vertex_generator: APB register setup, grid
// point items on the s_ stream, vertex/index/reject items checked on the m_ stream.
// Depends on tvg_pkg and the RTL of torus_vertex_generator.
`timescale 1ns / 1ps

module torus_vertex_generator_tb;
    import tvg_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;

    // one result item as it travels on the m_ stream
    typedef struct {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_z;
        logic [NORM_W-1:0] norm_x;
        logic [NORM_W-1:0] norm_y;
        logic [NORM_W-1:0] norm_z;
        logic [TEX_W-1:0]  tex_u;
        logic [TEX_W-1:0]  tex_v;
        logic [VIDX_W-1:0] index_value;
        logic              last;
    } mesh_item_t;

    // directed grid point; reject rows carry their expectation typed in
    typedef struct {
        int unsigned ring;
        int unsigned tube;
        bit          typed_reject;
    } point_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_AW-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    torus_vertex_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow copy of the configuration registers, as stored (masked to width)
    logic [15:0]        radius_major;
    logic [15:0]        radius_minor;
    logic [STEP_W-1:0]  steps_major;
    logic [STEP_W-1:0]  steps_minor;

    int unsigned  quarter_wave [0:QUARTER];
    mesh_item_t   pending_items [$];
    int           error_count;
    int           points_sent;
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    bit           hold_req;
    bit           hold_done;
    int           hold_cnt;
    int           stall_cnt;

    // quarter-wave Q1.14 sine, Horner series in Q28
    task automatic fill_sine_table();
        longint unsigned x, x2, r, s, e;
        int unsigned divs [6];
        divs = '{156, 110, 72, 42, 20, 6};
        for (int k = 0; k <= QUARTER; k++) begin
            x  = (longint'(k) * 64'd421657428) / QUARTER;
            x2 = (x * x) >> 28;
            r  = 64'd1 << 28;
            for (int d = 0; d < 6; d++) begin
                r = (64'd1 << 28) - ((x2 * r) >> 28) / divs[d];
            end
            s = (x * r) >> 28;
            e = (s + 64'd8192) >> 14;
            if (e > 64'd16384) begin
                e = 64'd16384;
            end
            quarter_wave[k] = int'(e);
        end
    endtask

    function automatic longint wave_value(int unsigned idx);
        int unsigned w, q, rr;
        w  = idx % SINE_TABLE_DEPTH;
        q  = w / QUARTER;
        rr = w % QUARTER;
        case (q)
            0: return  longint'(quarter_wave[rr]);
            1: return  longint'(quarter_wave[QUARTER - rr]);
            2: return -longint'(quarter_wave[rr]);
            default: return -longint'(quarter_wave[QUARTER - rr]);
        endcase
    endfunction

    function automatic int unsigned limit_steps(logic [STEP_W-1:0] s);
        if (s == 0) begin
            return 1;
        end
        if (int'(s) > MAX_STEPS) begin
            return MAX_STEPS;
        end
        return int'(s);
    endfunction

    function automatic longint clip_pos(longint v);
        if (v > 131071) begin
            return 131071;
        end
        if (v < -131072) begin
            return -131072;
        end
        return v;
    endfunction

    function automatic mesh_item_t reject_item();
        mesh_item_t it;
        it = '{kind: KIND_REJECT, last: 1'b1, default: '0};
        return it;
    endfunction

    // queue up the vertex and the cell's indices for one grid point, or a reject item if it is out of range
    function automatic void expect_torus_point(int unsigned i, int unsigned j);
        int unsigned m, n, a, b, ia, ib, cur, nxt, base;
        longint      sa, ca, sb, cb, w;
        bit          has_quad;
        mesh_item_t  v;
        mesh_item_t  t;
        int unsigned corner [6];
        m = limit_steps(steps_major);
        n = limit_steps(steps_minor);
        if (i > m || j > n) begin
            pending_items.push_back(reject_item());
            return;
        end
        a  = (i << 16) / m;
        b  = (j << 16) / n;
        ia = ((a & 16'hFFFF) * SINE_TABLE_DEPTH) >> 16;
        ib = ((b & 16'hFFFF) * SINE_TABLE_DEPTH) >> 16;
        sa = wave_value(ia);
        ca = wave_value(ia + QUARTER);
        sb = wave_value(ib);
        cb = wave_value(ib + QUARTER);
        // >>> is a floor shift on signed values
        w    = longint'(radius_major) + ((longint'(radius_minor) * cb) >>> 14);
        cur  = i * (n + 1) + j;
        has_quad = (i < m) && (j < n);
        v = '{kind: KIND_VERTEX, default: '0};
        v.slot   = SLOT_W'(cur);
        v.pos_x  = POS_W'(clip_pos((w * ca) >>> 14));
        v.pos_y  = POS_W'(clip_pos((longint'(radius_minor) * sb) >>> 14));
        v.pos_z  = POS_W'(clip_pos((w * sa) >>> 14));
        v.norm_x = NORM_W'((cb * ca) >>> 14);
        v.norm_y = NORM_W'(sb);
        v.norm_z = NORM_W'((cb * sa) >>> 14);
        v.tex_u  = TEX_W'(a);
        v.tex_v  = TEX_W'(b);
        v.last   = !has_quad;
        pending_items.push_back(v);
        if (!has_quad) begin
            return;
        end
        // two triangles per cell: c, n, c+1 and c+1, n, n+1
        nxt  = cur + n + 1;
        base = (i * n + j) * 6;
        corner = '{cur, nxt, cur + 1, cur + 1, nxt, nxt + 1};
        for (int k = 0; k < 6; k++) begin
            t = '{kind: KIND_INDEX, default: '0};
            t.slot        = SLOT_W'(base + k);
            t.index_value = VIDX_W'(corner[k]);
            t.last        = (k == 5);
            pending_items.push_back(t);
        end
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // drive: one APB write, setup then access, then back to idle
    task automatic apb_write(logic [1:0] reg_sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({reg_sel, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (reg_sel)
            REG_RING_RADIUS: radius_major = value[15:0];
            REG_TUBE_RADIUS: radius_minor = value[15:0];
            REG_RING_STEPS:  steps_major  = value[STEP_W-1:0];
            default:         steps_minor  = value[STEP_W-1:0];
        endcase
    endtask

    // wait for the block to drain before touching the registers
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_items.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_geometry(int unsigned rmaj, int unsigned rmin,
                                 int unsigned m, int unsigned n);
        settle_idle();
        apb_write(REG_RING_RADIUS, rmaj);
        apb_write(REG_TUBE_RADIUS, rmin);
        apb_write(REG_RING_STEPS, m);
        apb_write(REG_TUBE_STEPS, n);
    endtask

    // offer one grid point; valid stays high into the next item unless we idle
    task automatic send_point(int unsigned i, int unsigned j, bit typed_reject);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, GRID_W'(j), GRID_W'(i)};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        if (typed_reject) begin
            pending_items.push_back(reject_item());
        end else begin
            expect_torus_point(i, j);
        end
        points_sent++;
        // idling schedule: receiver-heavy at first, then sender-heavy, then free running
        if (points_sent == 110) begin
            send_idle_pct = 53;
            recv_idle_pct = 22;
        end else if (points_sent == 220) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end else if (points_sent == 260) begin
            hold_req = 1'b1;
        end
    endtask

    // mostly valid grid points, some anywhere in the 9-bit field
    task automatic send_random_points(int count);
        int unsigned m, n;
        m = limit_steps(steps_major);
        n = limit_steps(steps_minor);
        send_point(0, 0, 1'b0);
        send_point(m, n, 1'b0);
        send_point(m - 1, n - 1, 1'b0);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 15) begin
                send_point($urandom_range(511), $urandom_range(511), 1'b0);
            end else begin
                send_point($urandom_range(m), $urandom_range(n), 1'b0);
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off to back up the queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // checker: compare each result item against the oldest expectation
    always @(posedge aclk) begin
        mesh_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_items.size() == 0) begin
                $display("%0t: unexpected item kind %0d slot %0h", $time, m_tuser,
                         m_tdata[18:0]);
                error_count++;
            end else begin
                want = pending_items.pop_front();
                check_field("kind",        want.kind,        m_tuser);
                check_field("slot",        want.slot,        m_tdata[18:0]);
                check_field("pos_x",       want.pos_x,       m_tdata[36:19]);
                check_field("pos_y",       want.pos_y,       m_tdata[54:37]);
                check_field("pos_z",       want.pos_z,       m_tdata[72:55]);
                check_field("norm_x",      want.norm_x,      m_tdata[88:73]);
                check_field("norm_y",      want.norm_y,      m_tdata[104:89]);
                check_field("norm_z",      want.norm_z,      m_tdata[120:105]);
                check_field("tex_u",       want.tex_u,       m_tdata[137:121]);
                check_field("tex_v",       want.tex_v,       m_tdata[154:138]);
                check_field("index_value", want.index_value, m_tdata[171:155]);
                check_field("last",        want.last,        m_tlast);
            end
        end
    end

    // watchdog: count cycles with no item moving on either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    point_row_t corner_rows [$];

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        points_sent   = 0;
        send_idle_pct = 22;
        recv_idle_pct = 53;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        hold_cnt      = 0;
        stall_cnt     = 0;
        radius_major  = 16'd256;
        radius_minor  = 16'd64;
        steps_major   = STEP_W'(16);
        steps_minor   = STEP_W'(8);
        fill_sine_table();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed points on the reset geometry (16 x 8)
        corner_rows = '{
            '{0,   0,   1'b0},   // origin cell
            '{3,   5,   1'b0},
            '{15,  7,   1'b0},   // last full cell
            '{16,  8,   1'b0},   // far seam corner: vertex only
            '{16,  0,   1'b0},   // ring seam
            '{0,   8,   1'b0},   // tube seam
            '{8,   4,   1'b0},   // half turn both ways
            '{17,  0,   1'b1},   // ring beyond limit
            '{0,   9,   1'b1},   // tube beyond limit
            '{256, 256, 1'b1},
            '{511, 511, 1'b1},   // all input bits set
            '{511, 0,   1'b1},
            '{0,   511, 1'b1}
        };
        foreach (corner_rows[r]) begin
            send_point(corner_rows[r].ring, corner_rows[r].tube,
                       corner_rows[r].typed_reject);
        end

        // geometry sweeps: smallest, largest, clamped steps, then random
        load_geometry(0, 0, 1, 1);
        send_random_points(60);
        load_geometry(65535, 65535, 256, 256);
        send_random_points(60);
        load_geometry(16'h1234, 16'h0ABC, 0, 511);
        send_random_points(60);
        load_geometry($urandom_range(65535), $urandom_range(65535),
                      $urandom_range(2, 40), $urandom_range(2, 40));
        send_random_points(60);
        load_geometry($urandom_range(65535), $urandom_range(65535),
                      $urandom_range(511), $urandom_range(511));
        send_random_points(50);

        // drain and report
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_items.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
